// File: src/picl_pkg.sv
// ----------------------------------------------------------------------------
// picl_pkg
// Shared types and constants of the PI current loop with test run.
// ----------------------------------------------------------------------------
`default_nettype none

package picl_pkg;

  localparam int GAIN_FRAC_BITS_DEF = 8;
  localparam int INTEGRAL_WIDTH_DEF = 32;

  localparam int CNT_W = 10;
  localparam int POT_W = 12;
  localparam int PWM_W = 12;
  localparam int CUR_W = 16;
  localparam int MEAS_W = 17;
  localparam int GAIN_W = 16;
  localparam int AMP_W = 15;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_INDEX_W = 3;

  localparam logic [GAIN_W-1:0] KP_GAIN_RST = 16'd205;
  localparam logic [GAIN_W-1:0] KI_GAIN_RST = 16'd102;
  localparam logic [POT_W-1:0] POT_LOW_RST = 12'd250;
  localparam logic [POT_W-1:0] POT_HIGH_RST = 12'd3845;
  localparam logic [AMP_W-1:0] REF_AMPLITUDE_RST = 15'd600;
  localparam logic [CNT_W-1:0] REF_HALF_PERIOD_RST = 10'd100;
  localparam logic [CNT_W-1:0] RUN_LENGTH_RST = 10'd400;
  localparam logic [PWM_W-1:0] BRIDGE_PERIOD_RST = 12'd2400;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_KP_GAIN         = 3'd0,
    REG_KI_GAIN         = 3'd1,
    REG_POT_LOW         = 3'd2,
    REG_POT_HIGH        = 3'd3,
    REG_REF_AMPLITUDE   = 3'd4,
    REG_REF_HALF_PERIOD = 3'd5,
    REG_RUN_LENGTH      = 3'd6,
    REG_BRIDGE_PERIOD   = 3'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    DRV_HOLD,
    DRV_PI,
    DRV_STOP
  } drv_mode_t;

  typedef struct packed {
    logic [GAIN_W-1:0] kp_gain;
    logic [GAIN_W-1:0] ki_gain;
    logic [POT_W-1:0]  pot_low;
    logic [POT_W-1:0]  pot_high;
    logic [AMP_W-1:0]  ref_amplitude;
    logic [CNT_W-1:0]  ref_half_period;
    logic [CNT_W-1:0]  run_length;
    logic [PWM_W-1:0]  bridge_period;
  } cfg_t;

  typedef struct packed {
    drv_mode_t                mode;
    logic                     log_valid;
    logic [CNT_W-1:0]         log_index;
    logic signed [CUR_W-1:0]  log_reference;
    logic signed [MEAS_W-1:0] log_measured;
    logic                     run_active;
    logic                     run_finished;
    logic                     end_stop_hit;
  } side_t;

endpackage

`default_nettype wire

// File: src/pi_current_loop_with_test_run_unit.sv
// ----------------------------------------------------------------------------
// pi_current_loop_with_test_run_unit
// PI current loop with square-wave test run, driving two bridge compares.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one transfer per control tick (in_tuser = 0) or run start
//            (in_tuser = 1), carrying the pot reading and raw current.
//   out_*  : exactly one result transfer per input transfer, in order:
//            compare values, logged sample, run and end-stop status.
//            out_tlast marks the last logged sample of a test run.
//   cfg_*  : register writes, always ready; write only while idle.
// Timing:
//   five register stages (input, control, multiply, sum, output), each item
//   passing through them in that order. One item per cycle is sustained while
//   the output is ready, as the integrator and counters update per transfer.
// Reset: registers take their default values, no run is active and both
//   compares equal the default PWM period.
// Stall: a stalled output fills the pipeline bubbles first; in_tready falls
//   only once every stage holds an item, and nothing is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module pi_current_loop_with_test_run_unit
  import picl_pkg::*;
#(
  parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF,
  parameter int INTEGRAL_WIDTH = INTEGRAL_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [31:0]            in_tdata,   // pot_sample, current_sample
  input  wire logic                   in_tuser,   // action
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // compare_a, compare_b, log_index, log_reference, log_measured,
  // run_active, end_stop_hit
  output logic [71:0]                 out_tdata,
  output logic                        out_tuser,  // log_valid
  output logic                        out_tlast,  // run_finished
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int PE_W  = GAIN_W + 1 + MEAS_W;
  localparam int PI_W  = GAIN_W + 1 + INTEGRAL_WIDTH;
  localparam int SUM_W = PI_W + 1;

  cfg_t cfg_r;

  logic                             v1_r, v2_r, v3_r, v4_r, vo_r;
  logic                             rdy1, rdy2, rdy3, rdy4;
  logic                             act_r;
  logic [POT_W-1:0]                 pot_r;
  logic signed [CUR_W-1:0]          cur_r;

  side_t                            side_c, side2_r, side3_r, side4_r, sideo_r;
  logic signed [MEAS_W-1:0]         err_c, err_r;
  logic signed [INTEGRAL_WIDTH-1:0] acc_c, acc_r;
  logic signed [PE_W-1:0]           pe_r;
  logic signed [PI_W-1:0]           pi_r;
  logic signed [SUM_W-1:0]          sum_r;
  logic [SUM_W-1:0]                 mag_abs;
  logic [SUM_W-1:0]                 mag_sh;
  logic [PWM_W-1:0]                 mag;
  logic [PWM_W-1:0]                 cmp_a_r, cmp_a_nxt;
  logic [PWM_W-1:0]                 cmp_b_r, cmp_b_nxt;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.kp_gain         <= KP_GAIN_RST;
      cfg_r.ki_gain         <= KI_GAIN_RST;
      cfg_r.pot_low         <= POT_LOW_RST;
      cfg_r.pot_high        <= POT_HIGH_RST;
      cfg_r.ref_amplitude   <= REF_AMPLITUDE_RST;
      cfg_r.ref_half_period <= REF_HALF_PERIOD_RST;
      cfg_r.run_length      <= RUN_LENGTH_RST;
      cfg_r.bridge_period   <= BRIDGE_PERIOD_RST;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_KP_GAIN:         cfg_r.kp_gain         <= cfg_data;
        REG_KI_GAIN:         cfg_r.ki_gain         <= cfg_data;
        REG_POT_LOW:         cfg_r.pot_low         <= cfg_data[POT_W-1:0];
        REG_POT_HIGH:        cfg_r.pot_high        <= cfg_data[POT_W-1:0];
        REG_REF_AMPLITUDE:   cfg_r.ref_amplitude   <= cfg_data[AMP_W-1:0];
        REG_REF_HALF_PERIOD: cfg_r.ref_half_period <= cfg_data[CNT_W-1:0];
        REG_RUN_LENGTH:      cfg_r.run_length      <= cfg_data[CNT_W-1:0];
        REG_BRIDGE_PERIOD:   cfg_r.bridge_period   <= cfg_data[PWM_W-1:0];
        default: ;
      endcase
    end
  end

  // stage ready chain
  assign rdy4      = !vo_r || out_tready;
  assign rdy3      = !v4_r || rdy4;
  assign rdy2      = !v3_r || rdy3;
  assign rdy1      = !v2_r || rdy2;
  assign in_tready = !v1_r || rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (in_tready) v1_r <= in_tvalid;
      if (rdy1)      v2_r <= v1_r;
      if (rdy2)      v3_r <= v2_r;
      if (rdy3)      v4_r <= v3_r;
      if (rdy4)      vo_r <= v4_r;
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      act_r <= in_tuser;
      pot_r <= in_tdata[POT_W-1:0];
      cur_r <= in_tdata[POT_W+CUR_W-1:POT_W];
    end
  end

  picl_ctrl #(
    .INTEGRAL_WIDTH(INTEGRAL_WIDTH)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .step_en        (v1_r && rdy1),
    .action         (act_r),
    .pot_sample     (pot_r),
    .current_sample (cur_r),
    .side           (side_c),
    .err            (err_c),
    .acc            (acc_c)
  );

  // control stage
  always_ff @(posedge clk) begin
    if (v1_r && rdy1) begin
      side2_r <= side_c;
      err_r   <= err_c;
      acc_r   <= acc_c;
    end
  end

  // multiply stage
  always_ff @(posedge clk) begin
    if (v2_r && rdy2) begin
      side3_r <= side2_r;
      pe_r    <= PE_W'($signed({1'b0, cfg_r.kp_gain})) * PE_W'(err_r);
      pi_r    <= PI_W'($signed({1'b0, cfg_r.ki_gain})) * PI_W'(acc_r);
    end
  end

  // sum stage
  always_ff @(posedge clk) begin
    if (v3_r && rdy3) begin
      side4_r <= side3_r;
      sum_r   <= {{(SUM_W-PE_W){pe_r[PE_W-1]}}, pe_r} + {pi_r[PI_W-1], pi_r};
    end
  end

  // magnitude, truncate toward zero, clamp to period
  assign mag_abs = sum_r[SUM_W-1] ? (~sum_r + 1'b1) : sum_r;
  assign mag_sh  = mag_abs >> GAIN_FRAC_BITS;

  always_comb begin
    if (|mag_sh[SUM_W-1:PWM_W] || mag_sh[PWM_W-1:0] > cfg_r.bridge_period) begin
      mag = cfg_r.bridge_period;
    end else begin
      mag = mag_sh[PWM_W-1:0];
    end
  end

  always_comb begin
    cmp_a_nxt = cmp_a_r;
    cmp_b_nxt = cmp_b_r;
    case (side4_r.mode)
      DRV_PI: begin
        if (!sum_r[SUM_W-1]) begin
          cmp_a_nxt = cfg_r.bridge_period - mag;
          cmp_b_nxt = cfg_r.bridge_period;
        end else begin
          cmp_a_nxt = cfg_r.bridge_period;
          cmp_b_nxt = cfg_r.bridge_period - mag;
        end
      end
      DRV_STOP: begin
        cmp_a_nxt = cfg_r.bridge_period;
        cmp_b_nxt = cfg_r.bridge_period;
      end
      default: ;
    endcase
  end

  // output stage, also holds the bridge compares between ticks
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_a_r <= BRIDGE_PERIOD_RST;
      cmp_b_r <= BRIDGE_PERIOD_RST;
    end else if (v4_r && rdy4) begin
      cmp_a_r <= cmp_a_nxt;
      cmp_b_r <= cmp_b_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (v4_r && rdy4) begin
      sideo_r <= side4_r;
    end
  end

  assign out_tvalid = vo_r;
  assign out_tuser  = sideo_r.log_valid;
  assign out_tlast  = sideo_r.run_finished;
  assign out_tdata  = {3'b000, sideo_r.end_stop_hit, sideo_r.run_active,
                       sideo_r.log_measured, sideo_r.log_reference,
                       sideo_r.log_index, cmp_b_r, cmp_a_r};

  // a finished run always logs its last sample
  a_last_logged: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser)
    else $error("run end without logged sample");

  // a finished run leaves no run active
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> !sideo_r.run_active)
    else $error("run still active after its last sample");

  // end stop aborts the run and logs nothing
  a_estop: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && sideo_r.end_stop_hit |-> !sideo_r.run_active && !out_tuser)
    else $error("end stop left run active or logged");

  // a logged sample belongs to a run that continues or just ended
  a_log_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> sideo_r.run_active || out_tlast)
    else $error("sample logged outside a run");

  // input is only stalled when the pipeline is full and the output is stalled
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> v1_r && v2_r && v3_r && v4_r && vo_r && !out_tready)
    else $error("input stalled with room in the pipeline");

endmodule

`default_nettype wire

// File: src/picl_ctrl.sv
// ----------------------------------------------------------------------------
// picl_ctrl
// Run sequencer and integrator: holds the run state, checks the end stop,
// forms the error and the saturated integral for one control tick.
// ----------------------------------------------------------------------------
`default_nettype none

module picl_ctrl
  import picl_pkg::*;
#(
  parameter int INTEGRAL_WIDTH = INTEGRAL_WIDTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire cfg_t                             cfg,
  input  wire logic                             step_en,
  input  wire logic                             action,
  input  wire logic [POT_W-1:0]                 pot_sample,
  input  wire logic signed [CUR_W-1:0]          current_sample,
  output side_t                                 side,
  output logic signed [MEAS_W-1:0]              err,
  output logic signed [INTEGRAL_WIDTH-1:0]      acc
);

  localparam logic signed [INTEGRAL_WIDTH-1:0] IMAX = {1'b0, {(INTEGRAL_WIDTH-1){1'b1}}};
  localparam logic signed [INTEGRAL_WIDTH-1:0] IMIN = {1'b1, {(INTEGRAL_WIDTH-1){1'b0}}};

  logic                              running_r, running_nxt;
  logic [CNT_W-1:0]                  sample_r, sample_nxt;
  logic [CNT_W-1:0]                  phase_r, phase_nxt;
  logic signed [CUR_W-1:0]           ref_r, ref_nxt;
  logic signed [INTEGRAL_WIDTH-1:0]  integral_r, integral_nxt;
  logic signed [INTEGRAL_WIDTH:0]    isum;
  logic [CNT_W-1:0]                  sample_inc;
  logic [CNT_W-1:0]                  phase_inc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r  <= 1'b0;
      sample_r   <= '0;
      phase_r    <= '0;
      ref_r      <= CUR_W'(REF_AMPLITUDE_RST);
      integral_r <= '0;
    end else if (step_en) begin
      running_r  <= running_nxt;
      sample_r   <= sample_nxt;
      phase_r    <= phase_nxt;
      ref_r      <= ref_nxt;
      integral_r <= integral_nxt;
    end
  end

  // error = reference - (-current)
  assign err  = MEAS_W'(ref_r) + MEAS_W'(current_sample);
  assign isum = {integral_r[INTEGRAL_WIDTH-1], integral_r}
              + {{(INTEGRAL_WIDTH+1-MEAS_W){err[MEAS_W-1]}}, err};

  always_comb begin
    if (isum[INTEGRAL_WIDTH] != isum[INTEGRAL_WIDTH-1]) begin
      acc = isum[INTEGRAL_WIDTH] ? IMIN : IMAX;
    end else begin
      acc = isum[INTEGRAL_WIDTH-1:0];
    end
  end

  assign sample_inc = sample_r + 1'b1;
  assign phase_inc  = phase_r + 1'b1;

  always_comb begin
    running_nxt  = running_r;
    sample_nxt   = sample_r;
    phase_nxt    = phase_r;
    ref_nxt      = ref_r;
    integral_nxt = integral_r;
    side         = '0;
    side.mode    = DRV_HOLD;

    if (action) begin
      if (!running_r) begin
        sample_nxt   = '0;
        phase_nxt    = '0;
        integral_nxt = '0;
        ref_nxt      = CUR_W'(cfg.ref_amplitude);
        running_nxt  = 1'b1;
      end
    end else if (pot_sample < cfg.pot_low || pot_sample > cfg.pot_high) begin
      side.end_stop_hit = 1'b1;
      side.mode         = DRV_STOP;
      running_nxt       = 1'b0;
      sample_nxt        = '0;
      phase_nxt         = '0;
      integral_nxt      = '0;
      ref_nxt           = CUR_W'(cfg.ref_amplitude);
    end else if (running_r) begin
      integral_nxt       = acc;
      side.mode          = DRV_PI;
      side.log_valid     = 1'b1;
      side.log_index     = sample_r;
      side.log_reference = ref_r;
      side.log_measured  = -MEAS_W'(current_sample);
      sample_nxt         = sample_inc;
      phase_nxt          = phase_inc;
      if (phase_inc == cfg.ref_half_period) begin
        ref_nxt   = -ref_r;
        phase_nxt = '0;
      end
      if (sample_inc == cfg.run_length) begin
        side.run_finished = 1'b1;
        side.mode         = DRV_STOP;
        running_nxt       = 1'b0;
        sample_nxt        = '0;
        phase_nxt         = '0;
        integral_nxt      = '0;
        ref_nxt           = CUR_W'(cfg.ref_amplitude);
      end
    end

    side.run_active = running_nxt;
  end

endmodule

`default_nettype wire
